>>> src/art_pkg.sv
// Shared constants, codes and transaction types of the retransmission table.
package art_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ID_W = 32;
	localparam int AGE_W = 8;
	localparam int TRY_W = 4;
	localparam int RES_W = 3;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	localparam logic [RES_W-1:0] EV_RECORDED = 3'd0;
	localparam logic [RES_W-1:0] EV_FULL = 3'd1;
	localparam logic [RES_W-1:0] EV_ACKED = 3'd2;
	localparam logic [RES_W-1:0] EV_RESEND = 3'd3;
	localparam logic [RES_W-1:0] EV_LOST = 3'd4;

	localparam logic REG_ACK_TIMEOUT = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	typedef struct packed {
		logic act;
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0] id;
		logic matched;
		logic free_found;
		logic [IDX_W-1:0] free_idx;
		logic pend_v;
		logic [RES_W-1:0] pend_res;
		logic [ID_W-1:0] pend_id;
		logic [TRY_W-1:0] pend_att;
		logic fl_v;
		logic [RES_W-1:0] fl_res;
		logic [ID_W-1:0] fl_id;
		logic [TRY_W-1:0] fl_att;
	} pkt_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic [ID_W-1:0] id;
	} wr_t;

endpackage

>>> src/art_cell.sv
// One table slot: holds an entry and processes the transaction passing along the chain.
module art_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [art_pkg::IDX_W-1:0] idx,
	input  logic [art_pkg::AGE_W-1:0] timeout,
	input  logic [art_pkg::TRY_W-1:0] limit,
	input  art_pkg::wr_t              wr,
	input  art_pkg::pkt_t             pkt_in,
	output art_pkg::pkt_t             pkt_out
);
	import art_pkg::*;

	logic valid_q, valid_d;
	logic [ID_W-1:0] id_q, id_d;
	logic [AGE_W-1:0] age_q, age_d, age_inc;
	logic [TRY_W-1:0] tries_q, tries_d;
	logic hit;
	pkt_t nxt, pkt_q;

	always_comb begin
		nxt = pkt_in;
		nxt.fl_v = 1'b0;
		nxt.fl_res = '0;
		nxt.fl_id = '0;
		nxt.fl_att = '0;
		valid_d = valid_q;
		id_d = id_q;
		age_d = age_q;
		tries_d = tries_q;
		hit = valid_q && (id_q == pkt_in.id);
		age_inc = (age_q == {AGE_W{1'b1}}) ? age_q : age_q + AGE_W'(1);
		if (pkt_in.act) begin
			case (pkt_in.mode)
				MODE_SEND: begin
					if (!pkt_in.matched && hit) begin
						nxt.matched = 1'b1;
						age_d = '0;
						tries_d = '0;
					end
					if (!pkt_in.free_found && !valid_q) begin
						nxt.free_found = 1'b1;
						nxt.free_idx = idx;
					end
				end
				MODE_ACK: begin
					if (!pkt_in.matched && hit) begin
						nxt.matched = 1'b1;
						valid_d = 1'b0;
					end
				end
				MODE_TICK: begin
					if (valid_q) begin
						age_d = age_inc;
						if (age_inc >= timeout) begin
							nxt.fl_v = pkt_in.pend_v;
							nxt.fl_res = pkt_in.pend_res;
							nxt.fl_id = pkt_in.pend_id;
							nxt.fl_att = pkt_in.pend_att;
							nxt.pend_v = 1'b1;
							nxt.pend_id = id_q;
							if (tries_q >= limit) begin
								valid_d = 1'b0;
								nxt.pend_res = EV_LOST;
								nxt.pend_att = '0;
							end else begin
								tries_d = tries_q + TRY_W'(1);
								age_d = '0;
								nxt.pend_res = EV_RESEND;
								nxt.pend_att = tries_q + TRY_W'(1);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (wr.en && (wr.idx == idx)) begin
			valid_d = 1'b1;
			id_d = wr.id;
			age_d = '0;
			tries_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pkt_q <= '0;
		end else begin
			valid_q <= valid_d;
			pkt_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
		age_q <= age_d;
		tries_q <= tries_d;
	end

	assign pkt_out = pkt_q;

endmodule

>>> src/ack_retransmit_table.sv
// Top level of the retransmission table: command intake, slot chain and result output.
//
// Channel   Direction  Handshake                      Content
// command   in         start && !busy                 mode, msg_id
// result    out        result_strobe, one cycle       event_res, event_id, attempt, last
// config    in         cfg_valid && cfg_ready         cfg_index, cfg_data
//
// Busy stays high while the transaction walks the chain of slot cells, one cell per cycle, plus
// one head and one tail stage. A new command can be accepted only after busy has fallen.
// Results come out in slot order, at most one per cycle, the final one in the cycle busy falls.
// Reset clears all slots, the configuration to its defaults and any transaction in flight.
// The receiver cannot stall; cfg_ready is always high.
module ack_retransmit_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [art_pkg::MODE_W-1:0] mode,
	input  logic [art_pkg::ID_W-1:0]   msg_id,
	output logic                       result_strobe,
	output logic [art_pkg::RES_W-1:0]  event_res,
	output logic [art_pkg::ID_W-1:0]   event_id,
	output logic [art_pkg::TRY_W-1:0]  attempt,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data
);
	import art_pkg::*;

	logic busy_q;
	logic [AGE_W-1:0] timeout_q;
	logic [TRY_W-1:0] limit_q;
	pkt_t head_q, tail_q, head_d;
	pkt_t chain [TABLE_DEPTH+1];
	wr_t wr;
	logic accept;
	logic fl_any;
	logic [RES_W-1:0] fl_res;
	logic [ID_W-1:0] fl_id;
	logic [TRY_W-1:0] fl_att;
	logic [TABLE_DEPTH+1:0] act_vec;
	logic strobe_q, last_q;
	logic [RES_W-1:0] res_q;
	logic [ID_W-1:0] id_q;
	logic [TRY_W-1:0] att_q;
	logic strobe_d, last_d;
	logic [RES_W-1:0] res_d;
	logic [ID_W-1:0] id_d;
	logic [TRY_W-1:0] att_d;

	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign cfg_ready = 1'b1;
	assign chain[0] = head_q;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		art_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(k)),
			.timeout (timeout_q),
			.limit   (limit_q),
			.wr      (wr),
			.pkt_in  (chain[k]),
			.pkt_out (chain[k+1])
		);
	end

	always_comb begin
		fl_any = 1'b0;
		fl_res = '0;
		fl_id = '0;
		fl_att = '0;
		for (int k = 1; k <= TABLE_DEPTH; k++) begin
			fl_any = fl_any | chain[k].fl_v;
			fl_res = fl_res | (chain[k].fl_res & {RES_W{chain[k].fl_v}});
			fl_id = fl_id | (chain[k].fl_id & {ID_W{chain[k].fl_v}});
			fl_att = fl_att | (chain[k].fl_att & {TRY_W{chain[k].fl_v}});
		end
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			act_vec[k] = chain[k].act;
		end
		act_vec[TABLE_DEPTH+1] = tail_q.act;
	end

	always_comb begin
		wr.en = tail_q.act && (tail_q.mode == MODE_SEND) && !tail_q.matched
			&& tail_q.free_found;
		wr.idx = tail_q.free_idx;
		wr.id = tail_q.id;
	end

	always_comb begin
		head_d = '0;
		head_d.act = accept;
		head_d.mode = mode;
		head_d.id = msg_id;
	end

	always_comb begin
		strobe_d = fl_any;
		last_d = 1'b0;
		res_d = fl_res;
		id_d = fl_id;
		att_d = fl_att;
		if (tail_q.act) begin
			last_d = 1'b1;
			id_d = tail_q.id;
			att_d = '0;
			case (tail_q.mode)
				MODE_SEND: begin
					strobe_d = 1'b1;
					res_d = (tail_q.matched || tail_q.free_found) ? EV_RECORDED : EV_FULL;
				end
				MODE_ACK: begin
					strobe_d = tail_q.matched;
					res_d = EV_ACKED;
				end
				MODE_TICK: begin
					strobe_d = tail_q.pend_v;
					res_d = tail_q.pend_res;
					id_d = tail_q.pend_id;
					att_d = tail_q.pend_att;
				end
				default: begin
					strobe_d = 1'b0;
					res_d = EV_RECORDED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			timeout_q <= AGE_W'(2);
			limit_q <= TRY_W'(3);
			head_q <= '0;
			tail_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACK_TIMEOUT: timeout_q <= cfg_data;
					REG_RETRY_LIMIT: limit_q <= cfg_data[TRY_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail_q.act) begin
				busy_q <= 1'b0;
			end
			head_q <= head_d;
			tail_q <= chain[TABLE_DEPTH];
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		res_q <= res_d;
		id_q <= id_d;
		att_q <= att_d;
	end

	assign result_strobe = strobe_q;
	assign event_res = res_q;
	assign event_id = id_q;
	assign attempt = att_q;
	assign last = last_q;

`ifndef SYNTH
	a_one_transaction: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one transaction in the slot chain");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy_q))
		else $error("result given with no transaction in progress");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && head_q.act)
		else $error("accepted transaction did not enter the chain");

	a_tail_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q.act |=> !busy_q)
		else $error("busy still high after the transaction left the chain");

	a_no_flush_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q.act |-> !fl_any)
		else $error("slot event collides with the final result");
`endif

endmodule
